>>> rtl/rba_pkg.sv
package rba_pkg;

  // Bitmap storage is organized as 32-bit words
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // Fixed field widths on the ports
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int SIZE_W = 9;
  localparam int STAT_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // Request types
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_RELEASE = 2'd2;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] release_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  granted_index;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  allocated_count;
  } out_item_t;

  // Which range the scan unit walks
  typedef enum logic [2:0] {
    SK_PROBE_CAND,
    SK_PROBE_REL,
    SK_FREE,
    SK_NEXT_SET_GRANT,
    SK_NEXT_SET_REL
  } scan_kind_t;

  // Which slot a map update touches
  typedef enum logic [1:0] {
    CK_GRANT_CAND,
    CK_GRANT_HIT,
    CK_RELEASE
  } commit_kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              cap_req;
    logic              scan_go;
    scan_kind_t        scan_kind;
    logic              commit;
    commit_kind_t      commit_kind;
    logic              fs_load;
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic busy;
    logic hit;
    logic is_release;
    logic fast_ok;
    logic rel_in_range;
    logic rel_is_fs;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/rba_ram.sv
module rba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rba_datapath.sv
module rba_datapath import rba_pkg::*; #(
  parameter int MAP_BITS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_item,
  input  logic              cfg_valid,
  input  logic [SIZE_W-1:0] cfg_data,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              out_ready,
  output logic              out_valid,
  output out_item_t         out_item
);

  localparam int NWORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SW     = WAW + BIT_W;
  localparam int XW     = (SW + 1 > SIZE_W) ? SW + 1 : SIZE_W;
  localparam int WPW    = XW - BIT_W;
  localparam int CW     = $clog2(MAP_BITS + 1);

  function automatic logic [XW-1:0] wrap_inc(input logic [XW-1:0] i,
                                             input logic [XW-1:0] lim);
    logic [XW-1:0] nx;
    nx = i + 1'b1;
    return (nx >= lim) ? '0 : nx;
  endfunction

  // Allocator state
  logic [SIZE_W-1:0] size_r;
  logic [XW-1:0]     last_r;
  logic [XW-1:0]     fs_r;
  logic              fsv_r;
  logic [CW-1:0]     cnt_r;
  logic [NWORDS-1:0] rv_r;

  // Current request and result
  logic              req_type_r;
  logic [XW-1:0]     req_idx_r;
  logic [STAT_W-1:0] status_r;
  logic              out_valid_r;
  out_item_t         out_r;

  // Scan unit: issue side
  logic              sc_issue_r;
  logic              sc_has2_r;
  logic              sc_want_set_r;
  logic [XW-1:0]     sc_lo_r;
  logic [XW-1:0]     sc_hi_r;
  logic [XW-1:0]     sc_e_r;
  logic [WPW-1:0]    sc_w_r;

  // Scan unit: evaluate side
  logic              ev_valid_r;
  logic              ev_rv_r;
  logic [WPW-1:0]    ev_w_r;
  logic [XW-1:0]     ev_lo_r;
  logic [XW-1:0]     ev_hi_r;
  logic [WORD_W-1:0] word_r;
  logic              hit_r;
  logic [XW-1:0]     hit_idx_r;

  logic [XW-1:0]     n;
  logic [XW-1:0]     cand;
  logic [XW-1:0]     su_lo, su_hi, su_e, cs, ce;
  logic              su_has2, su_want_set, su_probe;
  logic [WPW-1:0]    lastw;
  logic              seg_ok, issue;
  logic [WORD_W-1:0] rdata, ev_word, lo_mask, hi_mask, pick;
  logic              ev_hit;
  logic [BIT_W-1:0]  ev_bit;
  logic [XW-1:0]     tgt;
  logic [WAW-1:0]    waddr;
  logic [WORD_W-1:0] wmask, wdata;
  logic              is_grant;

  // Active size: zero or oversize means the whole map
  assign n = (size_r == '0 || XW'(size_r) > XW'(MAP_BITS)) ? XW'(MAP_BITS) : XW'(size_r);
  assign cand = wrap_inc(last_r, n);

  // Status toward the controller
  assign stat.busy         = sc_issue_r || ev_valid_r;
  assign stat.hit          = hit_r;
  assign stat.is_release   = (req_type_r == REQ_RELEASE);
  assign stat.fast_ok      = !fsv_r || (cand != fs_r);
  assign stat.rel_in_range = (req_idx_r < n);
  assign stat.rel_is_fs    = fsv_r && (req_idx_r == fs_r);
  assign stat.out_free     = !out_valid_r || out_ready;

  // Scan setup: a single-slot probe or a circular range
  always_comb begin
    su_probe    = 1'b1;
    su_want_set = 1'b1;
    cs          = cand;
    ce          = cand;
    case (cmd.scan_kind)
      SK_PROBE_CAND: begin
        cs = cand;
      end
      SK_PROBE_REL: begin
        cs = req_idx_r;
      end
      SK_FREE: begin
        su_probe    = 1'b0;
        su_want_set = 1'b0;
        cs          = wrap_inc(cand, n);
        ce          = cand;
      end
      SK_NEXT_SET_GRANT: begin
        su_probe = 1'b0;
        cs       = wrap_inc(hit_idx_r, n);
        ce       = hit_idx_r + 1'b1;
      end
      SK_NEXT_SET_REL: begin
        su_probe = 1'b0;
        cs       = wrap_inc(req_idx_r, n);
        ce       = req_idx_r;
      end
      default: begin
        cs = cand;
      end
    endcase
    if (su_probe) begin
      su_lo   = cs;
      su_hi   = cs + 1'b1;
      su_e    = cs;
      su_has2 = 1'b0;
    end else begin
      // [s, n) then [0, e); a start at zero covers [0, e) alone
      su_lo   = cs;
      su_hi   = (cs == '0) ? ce : n;
      su_e    = ce;
      su_has2 = (cs != '0);
    end
  end

  // Issue one word read per cycle within the current segment
  assign lastw  = WPW'((sc_hi_r - 1'b1) >> BIT_W);
  assign seg_ok = (sc_lo_r < sc_hi_r) && (sc_w_r <= lastw);
  assign issue  = sc_issue_r && seg_ok && !ev_hit;

  // Evaluate the returned word against the segment bounds
  assign ev_word = ev_rv_r ? rdata : '0;
  assign lo_mask = (ev_w_r == ev_lo_r[XW-1:BIT_W]) ?
                   ({WORD_W{1'b1}} << ev_lo_r[BIT_W-1:0]) : {WORD_W{1'b1}};
  assign hi_mask = (ev_w_r < ev_hi_r[XW-1:BIT_W]) ? {WORD_W{1'b1}} :
                   (ev_w_r == ev_hi_r[XW-1:BIT_W]) ?
                   ~({WORD_W{1'b1}} << ev_hi_r[BIT_W-1:0]) : '0;
  assign pick    = (sc_want_set_r ? ev_word : ~ev_word) & lo_mask & hi_mask;
  assign ev_hit  = ev_valid_r && (|pick);

  // Lowest candidate bit in the word
  always_comb begin
    ev_bit = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (pick[j]) begin
        ev_bit = BIT_W'(j);
      end
    end
  end

  // Map update: set or clear one bit of the last evaluated word
  always_comb begin
    case (cmd.commit_kind)
      CK_GRANT_CAND: tgt = cand;
      CK_GRANT_HIT:  tgt = hit_idx_r;
      CK_RELEASE:    tgt = req_idx_r;
      default:       tgt = cand;
    endcase
  end

  assign is_grant = (cmd.commit_kind != CK_RELEASE);
  assign waddr    = tgt[BIT_W+WAW-1:BIT_W];
  assign wmask    = {{(WORD_W-1){1'b0}}, 1'b1} << tgt[BIT_W-1:0];
  assign wdata    = is_grant ? (word_r | wmask) : (word_r & ~wmask);

  rba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_map (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (sc_w_r[WAW-1:0]),
    .rdata (rdata)
  );

  // Scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_issue_r <= 1'b0;
      ev_valid_r <= 1'b0;
      hit_r      <= 1'b0;
    end else if (cmd.scan_go) begin
      sc_issue_r <= 1'b1;
      ev_valid_r <= 1'b0;
      hit_r      <= 1'b0;
    end else if (ev_hit) begin
      sc_issue_r <= 1'b0;
      ev_valid_r <= 1'b0;
      hit_r      <= 1'b1;
    end else begin
      ev_valid_r <= issue;
      if (sc_issue_r && !seg_ok && !sc_has2_r) begin
        sc_issue_r <= 1'b0;
      end
    end
  end

  // Scan payload
  always_ff @(posedge clk) begin
    if (cmd.scan_go) begin
      sc_lo_r       <= su_lo;
      sc_hi_r       <= su_hi;
      sc_e_r        <= su_e;
      sc_has2_r     <= su_has2;
      sc_want_set_r <= su_want_set;
      sc_w_r        <= su_lo[XW-1:BIT_W];
    end else if (sc_issue_r && !ev_hit) begin
      if (seg_ok) begin
        sc_w_r <= sc_w_r + 1'b1;
      end else if (sc_has2_r) begin
        // wrap to the second segment
        sc_lo_r   <= '0;
        sc_hi_r   <= sc_e_r;
        sc_w_r    <= '0;
        sc_has2_r <= 1'b0;
      end
    end
    if (issue) begin
      ev_w_r  <= sc_w_r;
      ev_lo_r <= sc_lo_r;
      ev_hi_r <= sc_hi_r;
      ev_rv_r <= rv_r[sc_w_r[WAW-1:0]];
    end
    if (ev_valid_r) begin
      word_r <= ev_word;
    end
    if (ev_hit) begin
      hit_idx_r <= {ev_w_r, ev_bit};
    end
  end

  // Allocator state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
      last_r <= XW'(MAP_BITS - 1);
      fs_r   <= '0;
      fsv_r  <= 1'b0;
      cnt_r  <= '0;
      rv_r   <= '0;
    end else begin
      if (cfg_valid) begin
        size_r <= cfg_data;
      end
      if (cmd.commit) begin
        rv_r[waddr] <= 1'b1;
        if (is_grant) begin
          last_r <= tgt;
          cnt_r  <= cnt_r + 1'b1;
          if (cmd.commit_kind == CK_GRANT_CAND && !fsv_r) begin
            fs_r  <= cand;
            fsv_r <= 1'b1;
          end
        end else begin
          cnt_r <= cnt_r - 1'b1;
          if (req_idx_r == last_r) begin
            last_r <= (req_idx_r == '0) ? (n - 1'b1) : (req_idx_r - 1'b1);
          end
        end
      end
      if (cmd.fs_load) begin
        fs_r  <= hit_r ? hit_idx_r : '0;
        fsv_r <= hit_r;
      end
    end
  end

  // Request capture and status
  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      req_type_r <= in_item.req_type;
      req_idx_r  <= XW'(in_item.release_index);
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.granted_index   <= (status_r == ST_OK && req_type_r == REQ_ALLOC) ?
                               IDX_W'(last_r) : '0;
      out_r.status          <= status_r;
      out_r.allocated_count <= CNT_W'(cnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Once a request is finished, a valid first-set pointer implies a non-empty map
  a_fs_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && fsv_r) |-> (cnt_r != '0))
    else $error("first-set pointer valid on an empty map");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAP_BITS))
    else $error("allocated count above map size");

  // A recorded hit ends the scan
  a_hit_stops: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> !(sc_issue_r || ev_valid_r))
    else $error("scan still running after a hit");

endmodule

>>> rtl/rba_ctrl.sv
module rba_ctrl import rba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_START   = 6'b000010,
    S_PROBE   = 6'b000100,
    S_SCAN    = 6'b001000,
    S_SETSCAN = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_req = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        if (!stat.is_release) begin
          cmd.scan_go   = 1'b1;
          cmd.scan_kind = SK_PROBE_CAND;
          state_nxt     = S_PROBE;
        end else if (!stat.rel_in_range) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_BAD_RELEASE;
          state_nxt      = S_FIN;
        end else begin
          cmd.scan_go   = 1'b1;
          cmd.scan_kind = SK_PROBE_REL;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!stat.busy) begin
          if (!stat.is_release) begin
            if (!stat.hit && stat.fast_ok) begin
              // slot after the last grant is free
              cmd.commit      = 1'b1;
              cmd.commit_kind = CK_GRANT_CAND;
              cmd.set_status  = 1'b1;
              cmd.status      = ST_OK;
              state_nxt       = S_FIN;
            end else begin
              cmd.scan_go   = 1'b1;
              cmd.scan_kind = SK_FREE;
              state_nxt     = S_SCAN;
            end
          end else if (!stat.hit) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_BAD_RELEASE;
            state_nxt      = S_FIN;
          end else begin
            cmd.commit      = 1'b1;
            cmd.commit_kind = CK_RELEASE;
            cmd.set_status  = 1'b1;
            cmd.status      = ST_OK;
            if (stat.rel_is_fs) begin
              cmd.scan_go   = 1'b1;
              cmd.scan_kind = SK_NEXT_SET_REL;
              state_nxt     = S_SETSCAN;
            end else begin
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_SCAN: begin
        if (!stat.busy) begin
          if (stat.hit) begin
            cmd.commit      = 1'b1;
            cmd.commit_kind = CK_GRANT_HIT;
            cmd.set_status  = 1'b1;
            cmd.status      = ST_OK;
            cmd.scan_go     = 1'b1;
            cmd.scan_kind   = SK_NEXT_SET_GRANT;
            state_nxt       = S_SETSCAN;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_NO_FREE;
            state_nxt      = S_FIN;
          end
        end
      end
      S_SETSCAN: begin
        if (!stat.busy) begin
          cmd.fs_load = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !stat.busy)
    else $error("scan running while idle");

  a_commit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !stat.busy)
    else $error("map write during a scan");

  a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_go |=> stat.busy)
    else $error("scan did not start");

endmodule

>>> rtl/roving_bitmap_allocator.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_item (req_type, release_index)
// out     | output    | out_valid / out_ready | out_item (granted_index, status, count)
// cfg     | input     | cfg_valid / cfg_ready | cfg_bits_in_use
//
// Allocate that hits a free slot, or release that needs no rescan: out_valid rises
// once the controller has passed through START, PROBE and FIN; in_ready returns with it.
// Each circular scan walks one 32-bit map word per cycle through the single RAM read
// port, up to MAP_BITS/32 + 1 words; a worst allocate runs a probe and two such scans.
// Reset clears the map at once through per-word valid flags; no clearing pass.
// A result waiting on out_ready does not block the next transfer in; that item
// then holds in its final state until the output register frees.
module roving_bitmap_allocator import rba_pkg::*; #(
  parameter int MAP_BITS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_bits_in_use
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Size register always takes a write
  assign cfg_ready = 1'b1;

  rba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rba_datapath #(
    .MAP_BITS (MAP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_bits_in_use),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> verif/testbench.sv
`default_nettype none

module testbench;
  import rba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 256;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 40;

  typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    in_item_t          item;
    logic [SIZE_W-1:0] size;
    bit                known;
    out_item_t         reply;
  } dir_row_t;

  // DUT connections
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_item = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_bits_in_use = SIZE_RESET;

  // Typed-in reply that travels with a directed request
  bit        typed_known = 1'b0;
  out_item_t typed_reply = '0;

  // Allocator shadow state
  logic [SIZE_W-1:0] size_reg = SIZE_RESET;
  bit                slot_used [SLOTS];
  int                last_grant = SLOTS - 1;
  int                first_used = 0;
  bit                first_used_ok = 1'b0;
  int                used_count = 0;

  out_item_t awaited_replies [$];
  dir_row_t  dir_rows [$];
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;
  int        hold_asks = 0;

  roving_bitmap_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_bits_in_use (cfg_bits_in_use)
  );

  always #6 clk = ~clk;

  // Zero or oversize settings fall back to the full map
  function automatic int live_slots();
    return (size_reg == 0 || size_reg > SIZE_W'(SLOTS)) ? SLOTS : int'(size_reg);
  endfunction

  function automatic int wrap_inc(int i, int n);
    return (i + 1 >= n) ? 0 : i + 1;
  endfunction

  // Next-fit allocate / release, one reply per request
  function automatic out_item_t allocator_step(in_item_t it);
    int        n;
    int        cand;
    int        probe;
    int        grant;
    int        rel;
    bit        scanned;
    bit        found;
    out_item_t r;
    n = live_slots();
    r = '0;
    r.status = ST_OK;
    if (it.req_type == REQ_ALLOC) begin
      cand = wrap_inc(last_grant, n);
      grant = -1;
      scanned = 1'b0;
      if (!slot_used[cand] && !(first_used_ok && cand == first_used)) begin
        grant = cand;
        if (!first_used_ok) begin
          first_used = cand;
          first_used_ok = 1'b1;
        end
      end else begin
        // circular search over the other slots
        scanned = 1'b1;
        probe = cand;
        for (int k = 1; k < n; k++) begin
          probe = wrap_inc(probe, n);
          if (!slot_used[probe]) begin
            grant = probe;
            break;
          end
        end
      end
      if (grant >= 0) begin
        slot_used[grant] = 1'b1;
        last_grant = grant;
        used_count++;
        r.granted_index = IDX_W'(grant);
        if (scanned) begin
          // grant itself is set, so this search always ends
          probe = wrap_inc(grant, n);
          while (!slot_used[probe]) probe = wrap_inc(probe, n);
          first_used = probe;
          first_used_ok = 1'b1;
        end
      end else begin
        r.status = ST_NO_FREE;
      end
    end else begin
      rel = int'(it.release_index);
      if (rel >= n || !slot_used[rel]) begin
        r.status = ST_BAD_RELEASE;
      end else begin
        slot_used[rel] = 1'b0;
        used_count--;
        if (rel == last_grant) last_grant = (rel == 0) ? n - 1 : rel - 1;
        if (first_used_ok && rel == first_used) begin
          found = 1'b0;
          probe = rel;
          for (int k = 1; k < n; k++) begin
            probe = wrap_inc(probe, n);
            if (slot_used[probe]) begin
              first_used = probe;
              found = 1'b1;
              break;
            end
          end
          if (!found) begin
            first_used = 0;
            first_used_ok = 1'b0;
          end
        end
      end
    end
    r.allocated_count = CNT_W'(used_count);
    return r;
  endfunction

  task automatic log_mismatch(string why, out_item_t want, out_item_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: expected idx %0d st %0d cnt %0d, got idx %0d st %0d cnt %0d",
               $time, why, want.granted_index, want.status, want.allocated_count,
               got.granted_index, got.status, got.allocated_count);
  endtask

  // Scoreboard: reply check first, then size writes, then new requests
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          log_mismatch("reply with nothing outstanding", '0, out_item);
        end else begin
          want = awaited_replies.pop_front();
          if (out_item.granted_index !== want.granted_index ||
              out_item.status !== want.status ||
              out_item.allocated_count !== want.allocated_count)
            log_mismatch("reply mismatch", want, out_item);
        end
      end
      if (cfg_valid && cfg_ready) size_reg = cfg_bits_in_use;
      if (in_valid && in_ready) begin
        want = allocator_step(in_item);
        if (typed_known) want = typed_reply;
        awaited_replies.push_back(want);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: mixes always-ready, random and run-length stall modes,
  // plus long hold-offs on request
  initial begin : rx_stall
    int  hold_done;
    int  mode;
    int  mode_left;
    int  run_left;
    bit  run_high;
    hold_done = 0;
    mode = 0;
    mode_left = 0;
    run_left = 0;
    run_high = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        out_ready <= 1'b0;
        hold_done++;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = int'($urandom_range(2));
          mode_left = int'($urandom_range(40, 300));
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(99) < 70);
          default: begin
            if (run_left == 0) begin
              run_high = !run_high;
              run_left = run_high ? int'($urandom_range(1, 16)) : int'($urandom_range(1, 6));
            end
            run_left--;
            out_ready <= run_high;
          end
        endcase
      end
    end
  end

  function automatic void add_row(row_kind_t kind, logic req, logic [IDX_W-1:0] idx,
                                  logic [SIZE_W-1:0] size, bit known,
                                  logic [IDX_W-1:0] g, logic [STAT_W-1:0] st,
                                  logic [CNT_W-1:0] cnt);
    dir_row_t row;
    row.kind = kind;
    row.item.req_type = req;
    row.item.release_index = idx;
    row.size = size;
    row.known = known;
    row.reply.granted_index = g;
    row.reply.status = st;
    row.reply.allocated_count = cnt;
    dir_rows.push_back(row);
  endfunction

  // Random set slot in the active range, or any index if none is set
  function automatic logic [IDX_W-1:0] pick_used_slot();
    int n;
    int start;
    int j;
    n = live_slots();
    start = int'($urandom_range(n - 1));
    for (int i = 0; i < n; i++) begin
      j = (start + i) % n;
      if (slot_used[j]) return IDX_W'(j);
    end
    return IDX_W'($urandom_range(255));
  endfunction

  function automatic in_item_t make_request(int alloc_pct);
    in_item_t it;
    if ($urandom_range(99) < 8) begin
      // noise: any type, any index
      it.req_type = 1'($urandom_range(1));
      it.release_index = IDX_W'($urandom_range(255));
    end else if ($urandom_range(99) < alloc_pct) begin
      it.req_type = REQ_ALLOC;
      it.release_index = IDX_W'($urandom_range(255));
    end else begin
      it.req_type = REQ_RELEASE;
      it.release_index = pick_used_slot();
    end
    return it;
  endfunction

  task automatic idle(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // One request transfer; returns at the accepting edge
  task automatic push_item(in_item_t it, bit known, out_item_t reply);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    typed_known <= known;
    typed_reply <= reply;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_bits_in_use <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Free every set slot of the active range, in rotated order
  task automatic release_all();
    int       n;
    int       start;
    int       j;
    in_item_t it;
    wait_drain();
    n = live_slots();
    start = int'($urandom_range(n - 1));
    for (int i = 0; i < n; i++) begin
      j = (start + i) % n;
      if (slot_used[j]) begin
        if ($urandom_range(3) == 0) idle(int'($urandom_range(1, 4)));
        it.req_type = REQ_RELEASE;
        it.release_index = IDX_W'(j);
        push_item(it, 1'b0, '0);
      end
    end
  endtask

  // Bursty random traffic with optional hold-off request and full pause
  task automatic send_random(int count, int alloc_pct, bit no_gaps, int hold_at, int pause_at);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_asks++;
      if (i == pause_at) wait_drain();
      if (burst == 0) begin
        burst = int'($urandom_range(1, 24));
        if (!no_gaps && $urandom_range(3) != 0) idle(int'($urandom_range(1, 8)));
      end
      burst--;
      push_item(make_request(alloc_pct), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [SIZE_W-1:0] new_size;
    int                pct;
    int                count;
    bit                keep;
    bit                no_gaps;
    int                hold_at;
    int                pause_at;

    // Directed table; typed replies only where obvious
    // fresh map: first grant is slot 0
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b1, 8'd0, ST_OK,          9'd1);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b1, 8'd1, ST_OK,          9'd2);
    // release of a clear slot at the top index
    add_row(ROW_ITEM, REQ_RELEASE, 8'd255, 9'd0, 1'b1, 8'd0, ST_BAD_RELEASE, 9'd2);
    // release of the first set slot forces a rescan
    add_row(ROW_ITEM, REQ_RELEASE, 8'd0,   9'd0, 1'b1, 8'd0, ST_OK,          9'd1);
    add_row(ROW_ITEM, REQ_RELEASE, 8'd0,   9'd0, 1'b1, 8'd0, ST_BAD_RELEASE, 9'd1);
    add_row(ROW_ITEM, REQ_RELEASE, 8'd1,   9'd0, 1'b1, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_RELEASE, 8'd1,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    // single-slot map: full map and release past the active size
    add_row(ROW_SIZE, REQ_ALLOC,   8'd0,   9'd1, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b1, 8'd0, ST_OK,          9'd1);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b1, 8'd0, ST_NO_FREE,     9'd1);
    add_row(ROW_ITEM, REQ_RELEASE, 8'd1,   9'd0, 1'b1, 8'd0, ST_BAD_RELEASE, 9'd1);
    add_row(ROW_ITEM, REQ_RELEASE, 8'd0,   9'd0, 1'b1, 8'd0, ST_OK,          9'd0);
    // two slots: fill, fail, then wrap through the scan
    add_row(ROW_SIZE, REQ_ALLOC,   8'd0,   9'd2, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b1, 8'd0, ST_NO_FREE,     9'd2);
    add_row(ROW_ITEM, REQ_RELEASE, 8'd0,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_RELEASE, 8'd1,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_RELEASE, 8'd0,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    // size zero acts as the full map
    add_row(ROW_SIZE, REQ_ALLOC,   8'd0,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_ALLOC,   8'hff,  9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_RELEASE, 8'd255, 9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    // oversize setting, then shrink while slots are held
    add_row(ROW_SIZE, REQ_ALLOC,   8'd0,   9'd511, 1'b0, 8'd0, ST_OK,        9'd0);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_SIZE, REQ_ALLOC,   8'd0,   9'd1, 1'b0, 8'd0, ST_OK,          9'd0);
    add_row(ROW_ITEM, REQ_ALLOC,   8'd0,   9'd0, 1'b0, 8'd0, ST_OK,          9'd0);

    // reset, then release at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SIZE) begin
        wait_drain();
        write_size(dir_rows[i].size);
      end else begin
        if ($urandom_range(1) == 0) idle(int'($urandom_range(1, 3)));
        push_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].reply);
      end
    end

    // Random phases over a spread of map sizes
    for (int ph = 0; ph < 9; ph++) begin
      keep = 1'b0;
      no_gaps = 1'b0;
      hold_at = -1;
      pause_at = -1;
      new_size = SIZE_RESET;
      pct = 50;
      count = 100;
      case (ph)
        0: begin new_size = 9'd256; pct = 85; count = 320; hold_at = 120; end
        1: begin new_size = 9'd2; pct = 55; count = 110; end
        2: begin new_size = 9'd1; count = 60; no_gaps = 1'b1; end
        3: begin
          new_size = SIZE_W'($urandom_range(3, 12));
          pct = 55;
          count = 150;
          pause_at = 75;
        end
        4: begin new_size = 9'd0; pct = 60; count = 120; end
        5: begin new_size = SIZE_W'($urandom_range(13, 64)); pct = 65; count = 140; keep = 1'b1; end
        6: begin new_size = SIZE_W'($urandom_range(257, 511)); pct = 70; count = 150; hold_at = 60; end
        7: begin new_size = SIZE_W'($urandom_range(2, 8)); count = 120; no_gaps = 1'b1; end
        default: begin new_size = 9'd256; pct = 45; count = 130; keep = 1'b1; end
      endcase
      // size writes normally follow an emptied map; some phases change it while held
      if (keep) wait_drain();
      else release_all();
      // nothing in flight across a size write
      wait_drain();
      write_size(new_size);
      send_random(count, pct, no_gaps, hold_at, pause_at);
    end
    release_all();

    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
